// File: rtl/core/pods_pkg.sv
// Package for the PLL output divider selection block.
// Holds the transaction payload types, status and register codes and shared widths.
// No dependencies.
`default_nettype none

package pods_pkg;

   // Widths settled by the register and payload fields.
   localparam int unsigned REF_W    = 30;
   localparam int unsigned MULT_W   = 8;
   localparam int unsigned RATE_W   = 32;
   localparam int unsigned VCO_W    = REF_W + MULT_W;
   localparam int unsigned DIV_W    = 6;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;

   // The quotient bits carried through the cell chain cover dividers up to 127.
   localparam int unsigned QUOT_MAX_W = 7;

   // Defaults for the top-level parameters.
   localparam int unsigned MAX_DIVIDER_DEF   = 63;
   localparam int unsigned DIVIDER_SHIFT_DEF = 25;

   // Register reset values.
   localparam logic [REF_W-1:0]  REF_RATE_RST = REF_W'(25000000);
   localparam logic [MULT_W-1:0] MULT_RST     = MULT_W'(44);
   localparam logic [RATE_W-1:0] MIN_RATE_RST = RATE_W'(27000000);
   localparam logic [RATE_W-1:0] MAX_RATE_RST = RATE_W'(600000000);

   typedef enum logic [1:0] {
      REG_REFERENCE_RATE = 2'd0,
      REG_MULTIPLIER     = 2'd1,
      REG_MIN_RATE       = 2'd2,
      REG_MAX_RATE       = 2'd3
   } pods_reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_WINDOW = 2'd1,
      STATUS_RANGE  = 2'd2
   } pods_status_type;

   typedef struct packed {
      logic [RATE_W-1:0] requested_rate;
      logic              check_window;
   } pods_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DIV_W-1:0]  divider;
      logic              exact;
      logic [WORD_W-1:0] divider_word;
   } pods_rsp_type;

   // Work carried from one division cell to the next.
   typedef struct packed {
      pods_status_type       status;
      logic [RATE_W-1:0]     target;
      logic [RATE_W-1:0]     rem;
      logic [QUOT_MAX_W-1:0] vco_low;
      logic [QUOT_MAX_W-1:0] quot;
   } pods_stage_type;

endpackage

`default_nettype wire

// File: rtl/core/pods_front.sv
// Entry stage: forms the VCO rate, runs the zero, window and overflow checks
// and seeds the division chain. Depends on pods_pkg.
`default_nettype none

module pods_front
   import pods_pkg::*;
#(
   parameter int unsigned MAX_DIVIDER = MAX_DIVIDER_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   output logic                   up_stall,
   input  wire pods_req_type      up_data,
   input  wire logic [REF_W-1:0]  ref_rate,
   input  wire logic [MULT_W-1:0] mult,
   input  wire logic [RATE_W-1:0] min_rate,
   input  wire logic [RATE_W-1:0] max_rate,
   output logic                   dn_valid,
   input  wire logic              dn_ready,
   output pods_stage_type         dn_data
);

   localparam int unsigned QW = $clog2(MAX_DIVIDER + 1);

   logic           valid_ff;
   logic           valid_in;
   pods_stage_type data_ff;
   pods_stage_type data_in;
   logic           ready;
   logic           take;
   logic [VCO_W-1:0] vco;
   logic [VCO_W-1:0] vco_hi;
   logic             overflow;
   logic [RATE_W-1:0] t;

   assign ready    = !valid_ff || dn_ready;
   assign up_stall = !ready;
   assign take     = up_valid && ready;

   always_comb begin
      t        = up_data.requested_rate;
      vco      = VCO_W'(ref_rate) * VCO_W'(mult);
      vco_hi   = vco >> QW;
      // A quotient at or above 2**QW can never be a legal divider.
      overflow = vco_hi >= VCO_W'(t);

      data_in.target  = t;
      data_in.rem     = vco_hi[RATE_W-1:0];
      data_in.vco_low = QUOT_MAX_W'(vco[QW-1:0]) << (QUOT_MAX_W - QW);
      data_in.quot    = '0;
      if (t == '0) begin
         data_in.status = STATUS_RANGE;
      end else if (up_data.check_window && (t < min_rate || t > max_rate)) begin
         data_in.status = STATUS_WINDOW;
      end else if (overflow) begin
         data_in.status = STATUS_RANGE;
      end else begin
         data_in.status = STATUS_OK;
      end

      valid_in = take || (valid_ff && !dn_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/pods_cell.sv
// One restoring division cell: brings down one VCO bit and produces one
// quotient bit per transaction. Depends on pods_pkg.
`default_nettype none

module pods_cell
   import pods_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           up_valid,
   output logic                up_ready,
   input  wire pods_stage_type up_data,
   output logic                dn_valid,
   input  wire logic           dn_ready,
   output pods_stage_type      dn_data
);

   logic           valid_ff;
   logic           valid_in;
   pods_stage_type data_ff;
   pods_stage_type data_in;
   logic           take;
   logic [RATE_W:0] trial;
   logic            fits;

   assign up_ready = !valid_ff || dn_ready;
   assign take     = up_valid && up_ready;

   always_comb begin
      trial = {up_data.rem, up_data.vco_low[QUOT_MAX_W-1]};
      fits  = trial >= {1'b0, up_data.target};

      data_in         = up_data;
      data_in.rem     = fits ? RATE_W'(trial - {1'b0, up_data.target}) : trial[RATE_W-1:0];
      data_in.vco_low = {up_data.vco_low[QUOT_MAX_W-2:0], 1'b0};
      data_in.quot    = {up_data.quot[QUOT_MAX_W-2:0], fits};

      valid_in = take || (valid_ff && !dn_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/pods_final.sv
// Last stage: rounds, range-checks the divider, packs the register word and
// holds the response transaction. Depends on pods_pkg.
`default_nettype none

module pods_final
   import pods_pkg::*;
#(
   parameter int unsigned MAX_DIVIDER   = MAX_DIVIDER_DEF,
   parameter int unsigned DIVIDER_SHIFT = DIVIDER_SHIFT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   output logic                   up_ready,
   input  wire pods_stage_type    up_data,
   input  wire logic [MULT_W-1:0] mult,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pods_rsp_type           rsp_data
);

   localparam int unsigned QV_W = QUOT_MAX_W + 1;
   localparam logic [QV_W-1:0] MAX_Q = QV_W'(MAX_DIVIDER);

   logic         valid_ff;
   logic         valid_in;
   pods_rsp_type data_ff;
   pods_rsp_type data_in;
   logic         take;
   logic [QV_W-1:0]   q;
   logic [QV_W-1:0]   q_round;
   logic [QV_W-1:0]   div;
   logic [RATE_W:0]   half_up;
   logic              round_up;
   logic              is_exact;
   pods_status_type   status;
   logic [WORD_W+QV_W-1:0] shifted;

   assign up_ready = !valid_ff || !rsp_stall;
   assign take     = up_valid && up_ready;

   always_comb begin
      q        = {1'b0, up_data.quot};
      // Rounding to nearest adds one when the remainder reaches half the target.
      half_up  = {2'b00, up_data.target[RATE_W-1:1]} + (RATE_W+1)'(up_data.target[0]);
      round_up = {1'b0, up_data.rem} >= half_up;
      q_round  = q + QV_W'(round_up);
      is_exact = up_data.rem == '0;
      status   = up_data.status;
      div      = '0;

      if (status == STATUS_OK) begin
         if (q == '0 || q > MAX_Q) begin
            status = STATUS_RANGE;
         end else if (is_exact) begin
            div = q;
         end else if (q_round > MAX_Q) begin
            status = STATUS_RANGE;
         end else begin
            div = q_round;
         end
      end

      shifted = (WORD_W+QV_W)'(div) << DIVIDER_SHIFT;

      data_in.status = status;
      if (status == STATUS_OK) begin
         data_in.divider      = div[DIV_W-1:0];
         data_in.exact        = is_exact;
         data_in.divider_word = shifted[WORD_W-1:0] | WORD_W'(mult);
      end else begin
         data_in.divider      = '0;
         data_in.exact        = 1'b0;
         data_in.divider_word = '0;
      end

      valid_in = take || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/pll_output_divider_select.sv
// Pipeline: one entry stage, one division cell per quotient bit, one output stage.
// Throughput: one transaction per cycle unless rsp_stall holds the pipeline;
// every stage holds its own transaction.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// Top level; depends on pods_pkg, pods_front, pods_cell and pods_final.
`default_nettype none

module pll_output_divider_select
   import pods_pkg::*;
#(
   parameter int unsigned MAX_DIVIDER   = MAX_DIVIDER_DEF,
   parameter int unsigned DIVIDER_SHIFT = DIVIDER_SHIFT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pods_req_type      req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pods_rsp_type           rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   localparam int unsigned QW = $clog2(MAX_DIVIDER + 1);

   logic [REF_W-1:0]  ref_rate_ff, ref_rate_in;
   logic [MULT_W-1:0] mult_ff, mult_in;
   logic [RATE_W-1:0] min_rate_ff, min_rate_in;
   logic [RATE_W-1:0] max_rate_ff, max_rate_in;
   logic               csr_write;
   pods_reg_index_type csr_index;

   pods_stage_type stage_data  [QW+1];
   logic           stage_valid [QW+1];
   logic           stage_ready [QW+1];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = pods_reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      ref_rate_in = ref_rate_ff;
      mult_in     = mult_ff;
      min_rate_in = min_rate_ff;
      max_rate_in = max_rate_ff;
      csr_prdata  = '0;
      case (csr_index)
         REG_REFERENCE_RATE: begin
            csr_prdata = CSR_DW'(ref_rate_ff);
            if (csr_write) ref_rate_in = csr_pwdata[REF_W-1:0];
         end
         REG_MULTIPLIER: begin
            csr_prdata = CSR_DW'(mult_ff);
            if (csr_write) mult_in = csr_pwdata[MULT_W-1:0];
         end
         REG_MIN_RATE: begin
            csr_prdata = min_rate_ff;
            if (csr_write) min_rate_in = csr_pwdata;
         end
         REG_MAX_RATE: begin
            csr_prdata = max_rate_ff;
            if (csr_write) max_rate_in = csr_pwdata;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_rate_ff <= REF_RATE_RST;
         mult_ff     <= MULT_RST;
         min_rate_ff <= MIN_RATE_RST;
         max_rate_ff <= MAX_RATE_RST;
      end else begin
         ref_rate_ff <= ref_rate_in;
         mult_ff     <= mult_in;
         min_rate_ff <= min_rate_in;
         max_rate_ff <= max_rate_in;
      end
   end

   pods_front #(
      .MAX_DIVIDER(MAX_DIVIDER)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_stall (req_stall),
      .up_data  (req_data),
      .ref_rate (ref_rate_ff),
      .mult     (mult_ff),
      .min_rate (min_rate_ff),
      .max_rate (max_rate_ff),
      .dn_valid (stage_valid[0]),
      .dn_ready (stage_ready[0]),
      .dn_data  (stage_data[0])
   );

   // One cell per quotient bit, most significant bit first.
   for (genvar i = 0; i < QW; i++) begin : g_cell
      pods_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[i]),
         .up_ready (stage_ready[i]),
         .up_data  (stage_data[i]),
         .dn_valid (stage_valid[i+1]),
         .dn_ready (stage_ready[i+1]),
         .dn_data  (stage_data[i+1])
      );
   end

   pods_final #(
      .MAX_DIVIDER   (MAX_DIVIDER),
      .DIVIDER_SHIFT (DIVIDER_SHIFT)
   ) u_final (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (stage_valid[QW]),
      .up_ready  (stage_ready[QW]),
      .up_data   (stage_data[QW]),
      .mult      (mult_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: sim/divider_select_checker.sv
`timescale 1ns / 100ps
// Checker for the PLL output divider selection block: watches the request, response and
// register channels, predicts each response and compares it field by field.
// Depends on pods_pkg.

module divider_select_checker
   import pods_pkg::*;
#(
   parameter int unsigned MAX_DIVIDER   = MAX_DIVIDER_DEF,
   parameter int unsigned DIVIDER_SHIFT = DIVIDER_SHIFT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire pods_req_type      req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire pods_rsp_type      rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   input  wire logic [CSR_DW-1:0] csr_prdata,
   input  wire logic              csr_pready,
   output int unsigned            mismatch_count,
   output int unsigned            in_flight
);

   logic [REF_W-1:0]  ref_rate = REF_RATE_RST;
   logic [MULT_W-1:0] mult     = MULT_RST;
   logic [RATE_W-1:0] min_rate = MIN_RATE_RST;
   logic [RATE_W-1:0] max_rate = MAX_RATE_RST;
   pods_rsp_type      expected_dividers[$];
   int unsigned       errors = 0;

   initial begin
      mismatch_count = 0;
      in_flight = 0;
   end

   function automatic pods_rsp_type select_divider(pods_req_type r);
      logic [63:0]  vco;
      logic [63:0]  quot;
      logic [63:0]  target;
      pods_rsp_type res;
      res = '0;
      quot = '0;
      target = 64'(r.requested_rate);
      // A zero target is rejected ahead of the window check.
      if (target == 0) begin
         res.status = STATUS_RANGE;
      end else if (r.check_window &&
                   (r.requested_rate < min_rate || r.requested_rate > max_rate)) begin
         res.status = STATUS_WINDOW;
      end else begin
         vco = 64'(ref_rate) * 64'(mult);
         quot = vco / target;
         if (quot == 0 || quot > MAX_DIVIDER) begin
            res.status = STATUS_RANGE;
         end else if (vco % target == 0) begin
            res.divider = DIV_W'(quot);
            res.exact = 1'b1;
         end else begin
            // The floor quotient passed; the rounded one must pass as well.
            quot = (vco + (target >> 1)) / target;
            if (quot == 0 || quot > MAX_DIVIDER) begin
               res.status = STATUS_RANGE;
            end else begin
               res.divider = DIV_W'(quot);
            end
         end
      end
      if (res.status == STATUS_OK) begin
         res.divider_word = WORD_W'(64'(mult) | (quot << DIVIDER_SHIFT));
      end
      return res;
   endfunction

   function automatic logic [CSR_DW-1:0] register_value(pods_reg_index_type idx);
      case (idx)
         REG_REFERENCE_RATE: return CSR_DW'(ref_rate);
         REG_MULTIPLIER:     return CSR_DW'(mult);
         REG_MIN_RATE:       return CSR_DW'(min_rate);
         REG_MAX_RATE:       return CSR_DW'(max_rate);
         default:            return '0;
      endcase
   endfunction

   always @(posedge clock) begin
      pods_rsp_type       want;
      pods_reg_index_type idx;
      idx = pods_reg_index_type'(csr_paddr[CSR_AW-1:2]);
      if (reset) begin
         ref_rate = REF_RATE_RST;
         mult = MULT_RST;
         min_rate = MIN_RATE_RST;
         max_rate = MAX_RATE_RST;
         expected_dividers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dividers.size() == 0) begin
               $error("response transaction with no request outstanding: %h", rsp_data);
               errors++;
            end else begin
               want = expected_dividers.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.divider !== want.divider) begin
                  $error("divider: expected %0d, got %0d", want.divider, rsp_data.divider);
                  errors++;
               end
               if (rsp_data.exact !== want.exact) begin
                  $error("exact: expected %0d, got %0d", want.exact, rsp_data.exact);
                  errors++;
               end
               if (rsp_data.divider_word !== want.divider_word) begin
                  $error("divider_word: expected %h, got %h", want.divider_word,
                         rsp_data.divider_word);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_dividers.push_back(select_divider(req_data));
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (idx)
                  REG_REFERENCE_RATE: ref_rate = csr_pwdata[REF_W-1:0];
                  REG_MULTIPLIER:     mult = csr_pwdata[MULT_W-1:0];
                  REG_MIN_RATE:       min_rate = csr_pwdata[RATE_W-1:0];
                  REG_MAX_RATE:       max_rate = csr_pwdata[RATE_W-1:0];
                  default:            ;
               endcase
            end else if (csr_prdata !== register_value(idx)) begin
               $error("prdata of %s: expected %h, got %h", idx.name(), register_value(idx),
                      csr_prdata);
               errors++;
            end
         end
      end
      mismatch_count <= errors;
      in_flight <= expected_dividers.size();
   end

endmodule

// File: sim/tb_pll_output_divider_select.sv
`timescale 1ns / 100ps
// Testbench top for pll_output_divider_select: drives requests and register accesses,
// stalls the response side, and reports the verdict. Depends on pods_pkg,
// divider_select_checker and the block itself.

module tb_pll_output_divider_select;
   import pods_pkg::*;

   localparam int unsigned LATENCY         = $clog2(MAX_DIVIDER_DEF + 1) + 2;
   localparam int unsigned HOLD_OFF_CYCLES = 120;
   localparam int unsigned DRAIN_LIMIT     = 20000;
   localparam int unsigned NUM_SETTINGS    = 8;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   pods_req_type      req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   pods_rsp_type      rsp_data;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   int unsigned       mismatch_count;
   int unsigned       in_flight;

   // Register values as last written; used only to aim the random targets.
   logic [REF_W-1:0]  cur_ref  = REF_RATE_RST;
   logic [MULT_W-1:0] cur_mult = MULT_RST;
   logic [RATE_W-1:0] cur_min  = MIN_RATE_RST;
   logic [RATE_W-1:0] cur_max  = MAX_RATE_RST;

   int unsigned burst_left    = 0;
   int unsigned hold_off_asks = 0;

   // Directed requests at the reset settings: {requested_rate, check_window}.
   logic [32:0] directed_requests [20] = '{
      {32'd0,          1'b1}, {32'd0,          1'b0},
      {32'hFFFF_FFFF,  1'b0}, {32'hFFFF_FFFF,  1'b1},
      {32'd1,          1'b0}, {32'd1,          1'b1},
      {32'd27000000,   1'b1}, {32'd26999999,   1'b1},
      {32'd600000000,  1'b1}, {32'd600000001,  1'b1},
      {32'd25000000,   1'b0}, {32'd1100000000, 1'b0},
      {32'd20000000,   1'b0}, {32'd20000000,   1'b1},
      {32'd17460317,   1'b0}, {32'd17254902,   1'b0},
      {32'd17187500,   1'b0}, {32'd1100000001, 1'b0},
      {32'd2200000000, 1'b0}, {32'd300000000,  1'b1}
   };

   // Register settings per phase: reference rate, multiplier, min rate, max rate.
   // The last phase picks its own values at random.
   logic [31:0] phase_settings [NUM_SETTINGS][4] = '{
      '{32'hFFFF_FFFF,   32'hFFFF_FFFF, 32'd0,          32'hFFFF_FFFF},
      '{32'd1,           32'd1,         32'd0,          32'd1},
      '{32'd100000000,   32'd8,         32'd600000000,  32'd27000000},
      '{32'd0,           32'd200,       32'd1000,       32'd2000000000},
      '{32'd12345678,    32'd0,         32'd0,          32'hFFFF_FFFF},
      '{32'd25000000,    32'd44,        32'd27000000,   32'd600000000},
      '{32'd4000000,     32'd150,       32'd5000000,    32'd900000000},
      '{32'd0,           32'd0,         32'd0,          32'd0}
   };
   int unsigned phase_items [NUM_SETTINGS] = '{200, 80, 200, 50, 50, 200, 150, 100};

   pll_output_divider_select #(
      .MAX_DIVIDER(MAX_DIVIDER_DEF),
      .DIVIDER_SHIFT(DIVIDER_SHIFT_DEF)
   ) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   divider_select_checker #(
      .MAX_DIVIDER(MAX_DIVIDER_DEF),
      .DIVIDER_SHIFT(DIVIDER_SHIFT_DEF)
   ) checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .mismatch_count(mismatch_count), .in_flight(in_flight)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Response side: stretches of free flow, random stalls, a toggling pattern and
   // heavy stalling, plus a long hold-off whenever the stimulus asks for one.
   initial begin
      int unsigned hold_off_done;
      int unsigned mode;
      int unsigned span;
      hold_off_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_asks != hold_off_done) begin
            hold_off_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 40);
            repeat (span) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 2) == 0);
                  2: rsp_stall <= ~rsp_stall;
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_request(input pods_req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (in_flight != 0 && waited < DRAIN_LIMIT);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // One register access: a setup phase, an access phase held until csr_pready, then an idle phase.
   task automatic csr_access(input logic write, input pods_reg_index_type idx,
                             input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] ref_value, input logic [31:0] mult_value,
                                input logic [31:0] min_value, input logic [31:0] max_value);
      csr_access(1'b1, REG_REFERENCE_RATE, ref_value);
      csr_access(1'b1, REG_MULTIPLIER, mult_value);
      csr_access(1'b1, REG_MIN_RATE, min_value);
      csr_access(1'b1, REG_MAX_RATE, max_value);
      cur_ref = ref_value[REF_W-1:0];
      cur_mult = mult_value[MULT_W-1:0];
      cur_min = min_value;
      cur_max = max_value;
      csr_access(1'b0, REG_REFERENCE_RATE, '0);
      csr_access(1'b0, REG_MULTIPLIER, '0);
      csr_access(1'b0, REG_MIN_RATE, '0);
      csr_access(1'b0, REG_MAX_RATE, '0);
   endtask

   // Half the picks aim the target at a divider of the current VCO rate, exactly or a little
   // off, so that the division and rounding paths see plenty of traffic.
   function automatic pods_req_type random_request();
      pods_req_type r;
      logic [63:0]  vco;
      logic [63:0]  base;
      int unsigned  pick;
      int unsigned  shift;
      vco = 64'(cur_ref) * 64'(cur_mult);
      pick = $urandom_range(0, 9);
      r.check_window = 1'($urandom_range(0, 1));
      r.requested_rate = $urandom();
      if (pick >= 3 && pick <= 7) begin
         base = vco / $urandom_range(1, MAX_DIVIDER_DEF + 1);
         if (pick >= 6) begin
            shift = $urandom_range(3, 12);
            base = $urandom_range(0, 1) ? base + (base >> shift) : base - (base >> shift);
         end
         if (base != 0 && base <= 64'hFFFF_FFFF) begin
            r.requested_rate = base[31:0];
         end
      end else if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: r.requested_rate = cur_min - 32'd1;
            1: r.requested_rate = cur_min;
            2: r.requested_rate = cur_max;
            default: r.requested_rate = cur_max + 32'd1;
         endcase
      end else if (pick == 9) begin
         r.requested_rate = $urandom_range(0, 3);
      end
      return r;
   endfunction

   initial begin
      logic [31:0] lo;
      logic [31:0] hi;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values read back before anything is written.
      csr_access(1'b0, REG_REFERENCE_RATE, '0);
      csr_access(1'b0, REG_MULTIPLIER, '0);
      csr_access(1'b0, REG_MIN_RATE, '0);
      csr_access(1'b0, REG_MAX_RATE, '0);

      foreach (directed_requests[i]) begin
         send_request(pods_req_type'(directed_requests[i]));
      end
      drain_results();

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         if (p == NUM_SETTINGS - 1) begin
            lo = $urandom();
            hi = $urandom();
            if (lo > hi) begin
               {lo, hi} = {hi, lo};
            end
            apply_setting($urandom_range(1000000, 200000000), $urandom_range(1, 255), lo, hi);
         end else begin
            apply_setting(phase_settings[p][0], phase_settings[p][1], phase_settings[p][2],
                          phase_settings[p][3]);
         end
         // Hold the response side off while requests keep coming, so the pipe backs up.
         if (p == 0 || p == 5) begin
            hold_off_asks <= hold_off_asks + 1;
         end
         repeat (phase_items[p]) begin
            send_request(random_request());
         end
         drain_results();
      end

      if (in_flight != 0) begin
         $error("%0d expected responses never arrived", in_flight);
      end
      if (mismatch_count == 0 && in_flight == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/pods_pkg.sv
rtl/core/pods_front.sv
rtl/core/pods_cell.sv
rtl/core/pods_final.sv
rtl/core/pll_output_divider_select.sv
sim/divider_select_checker.sv
sim/tb_pll_output_divider_select.sv
